### rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CountW   = $clog2(MaxBytes + 1);

  typedef enum logic [3:0] {
    ST_BYTE        = 4'd0,
    ST_CLOSED      = 4'd1,
    ST_NO_OPEN     = 4'd2,
    ST_UNTERM      = 4'd3,
    ST_BAD_END_ESC = 4'd4,
    ST_BAD_ESC     = 4'd5,
    ST_TRUNC_HEX   = 4'd6,
    ST_BAD_HEX     = 4'd7,
    ST_BAD_LOW     = 4'd8,
    ST_LONE_HIGH   = 4'd9
  } status_e;

  // results caused by one source byte, first byte in slot 0
  typedef struct packed {
    logic [CountW-1:0]            count;
    logic [MaxBytes-1:0][7:0]     bytes;
    status_e                      status;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/json_string_unescape_utf8.sv
// Channel  Dir  tdata           tuser          tlast
// s_axis   in   data_byte[7:0]  end_mark       -
// m_axis   out  out_byte[7:0]   status[3:0]    last
//
// One source word is taken per cycle while each gives at most one result and the output is ready.
// A \u escape that yields 2 to 4 UTF-8 bytes stalls the input until only its last byte
// is left in the result buffer, which sends one word per cycle while the output is ready.
// A result passes through the input register and then the result buffer on its way out.
// Reset returns the decoder to waiting for an opening quote and empties
// both the input register and the result buffer.
// A stalled output holds its word; the input register then fills and stalls.
`default_nettype none

module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  wire logic       s_tuser_i,   // [0] end_mark
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  output logic [7:0]      m_tdata_o,   // [7:0] out_byte
  output logic [3:0]      m_tuser_o,   // [3:0] status
  output logic            m_tlast_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       can_take;
  logic       advance;
  bundle_t    bundle;
  status_e    status;

  assign advance    = in_valid_q && can_take;
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
      in_end_q <= s_tuser_i;
    end
  end

  jsu_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (in_byte_q),
    .end_mark_i  (in_end_q),
    .bundle_o    (bundle)
  );

  jsu_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .bundle_i   (bundle),
    .can_take_o (can_take),
    .valid_o    (m_tvalid_o),
    .ready_i    (m_tready_i),
    .byte_o     (m_tdata_o),
    .status_o   (status),
    .last_o     (m_tlast_o)
  );

  assign m_tuser_o = status;

  // an error or close word is always alone and carries no byte
  a_code_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o != ST_BYTE) |-> (m_tdata_o == 8'h00 && m_tlast_o))
    else $error("status word not alone or carries data");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> in_valid_q)
    else $error("accepted word lost from input register");

endmodule

`default_nettype wire

### rtl/jsu_step.sv
`default_nettype none

module jsu_step
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_mark_i,
  output bundle_t         bundle_o
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_BODY,
    PH_ESC,
    PH_HEX_HIGH,
    PH_AFTER_HIGH,
    PH_AFTER_HIGH_BS,
    PH_HEX_LOW
  } phase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6e;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  high_q, high_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;

  function automatic bundle_t put(input logic [7:0] b, input status_e st);
    bundle_t r;
    r = '0;
    r.count = CountW'(1);
    r.bytes[0] = b;
    r.status = st;
    return r;
  endfunction

  function automatic bundle_t encode(input logic [20:0] cp);
    bundle_t r;
    r = '0;
    r.status = ST_BYTE;
    if (cp <= 21'h7f) begin
      r.count = CountW'(1);
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      r.count = CountW'(2);
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.count = CountW'(3);
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.count = CountW'(4);
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  always_comb begin
    hex_ok = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      hex_val = 4'(data_byte_i - 8'h57);
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      hex_val = 4'(data_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], hex_val};
  // 0x10000 plus the ten bits of each half
  assign pair_cp = 21'h10000 + {1'b0, high_q, acc_new[9:0]};

  always_comb begin
    phase_d = phase_q;
    hex_cnt_d = hex_cnt_q;
    acc_d = acc_q;
    high_d = high_q;
    bundle_o = '0;
    bundle_o.status = ST_BYTE;

    // error: one coded word, then back to waiting with everything cleared
    case (phase_q)
      PH_BODY: begin
        if (end_mark_i) begin
          bundle_o = put(8'h00, ST_UNTERM);
          phase_d = PH_WAIT;
          hex_cnt_d = '0;
          acc_d = '0;
          high_d = '0;
        end else if (data_byte_i == ChQuote) begin
          phase_d = PH_WAIT;
          bundle_o = put(8'h00, ST_CLOSED);
        end else if (data_byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          bundle_o = put(data_byte_i, ST_BYTE);
        end
      end
      PH_ESC: begin
        if (end_mark_i) begin
          bundle_o = put(8'h00, ST_BAD_END_ESC);
          phase_d = PH_WAIT;
          hex_cnt_d = '0;
          acc_d = '0;
          high_d = '0;
        end else begin
          phase_d = PH_BODY;
          case (data_byte_i)
            ChQuote, ChBslash, ChSlash: bundle_o = put(data_byte_i, ST_BYTE);
            ChB: bundle_o = put(8'h08, ST_BYTE);
            ChF: bundle_o = put(8'h0c, ST_BYTE);
            ChN: bundle_o = put(8'h0a, ST_BYTE);
            ChR: bundle_o = put(8'h0d, ST_BYTE);
            ChT: bundle_o = put(8'h09, ST_BYTE);
            ChU: begin
              phase_d = PH_HEX_HIGH;
              hex_cnt_d = '0;
              acc_d = '0;
            end
            default: begin
              bundle_o = put(8'h00, ST_BAD_ESC);
              phase_d = PH_WAIT;
              hex_cnt_d = '0;
              acc_d = '0;
              high_d = '0;
            end
          endcase
        end
      end
      PH_HEX_HIGH, PH_HEX_LOW: begin
        if (end_mark_i || !hex_ok) begin
          bundle_o = put(8'h00, end_mark_i ? ST_TRUNC_HEX : ST_BAD_HEX);
          phase_d = PH_WAIT;
          hex_cnt_d = '0;
          acc_d = '0;
          high_d = '0;
        end else if (hex_cnt_q != 2'd3) begin
          acc_d = acc_new;
          hex_cnt_d = hex_cnt_q + 2'd1;
        end else begin
          hex_cnt_d = '0;
          acc_d = '0;
          if (phase_q == PH_HEX_HIGH) begin
            if (acc_new[15:10] == 6'b110110) begin
              high_d = acc_new[9:0];
              phase_d = PH_AFTER_HIGH;
            end else begin
              phase_d = PH_BODY;
              bundle_o = encode({5'd0, acc_new});
            end
          end else if (acc_new[15:10] == 6'b110111) begin
            phase_d = PH_BODY;
            high_d = '0;
            bundle_o = encode(pair_cp);
          end else begin
            bundle_o = put(8'h00, ST_BAD_LOW);
            phase_d = PH_WAIT;
            high_d = '0;
          end
        end
      end
      PH_AFTER_HIGH, PH_AFTER_HIGH_BS: begin
        if (end_mark_i ||
            data_byte_i != ((phase_q == PH_AFTER_HIGH) ? ChBslash : ChU)) begin
          bundle_o = put(8'h00, ST_LONE_HIGH);
          phase_d = PH_WAIT;
          hex_cnt_d = '0;
          acc_d = '0;
          high_d = '0;
        end else if (phase_q == PH_AFTER_HIGH) begin
          phase_d = PH_AFTER_HIGH_BS;
        end else begin
          phase_d = PH_HEX_LOW;
          hex_cnt_d = '0;
          acc_d = '0;
        end
      end
      default: begin
        if (end_mark_i || data_byte_i != ChQuote) begin
          bundle_o = put(8'h00, ST_NO_OPEN);
          phase_d = PH_WAIT;
          hex_cnt_d = '0;
          acc_d = '0;
          high_d = '0;
        end else begin
          phase_d = PH_BODY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      hex_cnt_q <= '0;
      acc_q <= '0;
      high_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q <= acc_d;
      high_q <= high_d;
    end
  end

endmodule

`default_nettype wire

### rtl/jsu_outbuf.sv
`default_nettype none

module jsu_outbuf
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire bundle_t    bundle_i,
  output logic            can_take_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [7:0]      byte_o,
  output status_e         status_o,
  output logic            last_o
);

  logic [CountW-1:0]        cnt_q, cnt_d;
  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  status_e                  status_q, status_d;
  logic                     pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = cnt_q != '0;
  assign last_o     = cnt_q == CountW'(1);
  assign byte_o     = buf_q[0];
  assign status_o   = status_q;
  // free now, or the final word leaves this cycle
  assign can_take_o = (cnt_q == '0) || (last_o && ready_i);

  always_comb begin
    cnt_d = cnt_q;
    buf_d = buf_q;
    status_d = status_q;
    if (load_i && bundle_i.count != '0) begin
      cnt_d = bundle_i.count;
      buf_d = bundle_i.bytes;
      status_d = bundle_i.status;
    end else if (pop) begin
      cnt_d = cnt_q - CountW'(1);
      // advance the queue by one word
      buf_d = {8'h00, buf_q[MaxBytes-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire
